// ----- hw/rtl/pbh_pkg.sv -----
package pbh_pkg;

  localparam int COUNT_BITS     = 22;
  localparam int NUM_BINS       = 256;
  localparam int BIN_BITS       = $clog2(NUM_BINS);
  localparam int SCALE_BITS     = 16;
  localparam int OUT_COUNT_BITS = 22;
  localparam int COLOR_BITS     = 8;
  localparam int PROD_BITS      = COUNT_BITS + SCALE_BITS;
  localparam int STEP_BITS      = $clog2(PROD_BITS);

  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(256);

  // sum of three colors divided by 3 as multiply by 683 / 2048
  localparam int SUM_BITS    = COLOR_BITS + 2;
  localparam int RECIP       = 683;
  localparam int RECIP_SHIFT = 11;
  localparam int BRIGHT_BITS = SUM_BITS + 10;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } pbh_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_UPDATE,
    ST_MULT,
    ST_DIVIDE,
    ST_DONE
  } pbh_state_t;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic [BIN_BITS-1:0]   bin_index;
  } pbh_in_t;

  typedef struct packed {
    logic [OUT_COUNT_BITS-1:0] bin_count;
    logic [OUT_COUNT_BITS-1:0] max_count;
    logic [SCALE_BITS-1:0]     bar_height;
  } pbh_out_t;

  typedef struct packed {
    logic latch;
    logic fetch;
    logic pix_write;
    logic clear;
    logic mult_load;
    logic div_step;
    logic out_load;
  } pbh_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       div_done;
    logic       out_free;
  } pbh_stat_t;

  function automatic logic [OUT_COUNT_BITS-1:0] to_out_count(
    input logic [COUNT_BITS-1:0] c
  );
    logic [63:0] w;
    w = 64'(c);
    return w[OUT_COUNT_BITS-1:0];
  endfunction

endpackage

// ----- hw/rtl/pbh_ctrl.sv -----
module pbh_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pbh_pkg::pbh_stat_t  stat,
  output pbh_pkg::pbh_cmd_t   cmd
);

  pbh_pkg::pbh_state_t state_r;
  pbh_pkg::pbh_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pbh_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != pbh_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      pbh_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = pbh_pkg::ST_FETCH;
        end
      end
      pbh_pkg::ST_FETCH: begin
        cmd.fetch = 1'b1;
        unique case (pbh_pkg::pbh_op_t'(stat.opcode))
          pbh_pkg::OP_PIXEL: state_nxt = pbh_pkg::ST_UPDATE;
          pbh_pkg::OP_READ:  state_nxt = pbh_pkg::ST_MULT;
          pbh_pkg::OP_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = pbh_pkg::ST_IDLE;
          end
          default: state_nxt = pbh_pkg::ST_IDLE;
        endcase
      end
      pbh_pkg::ST_UPDATE: begin
        cmd.pix_write = 1'b1;
        state_nxt     = pbh_pkg::ST_IDLE;
      end
      pbh_pkg::ST_MULT: begin
        cmd.mult_load = 1'b1;
        state_nxt     = pbh_pkg::ST_DIVIDE;
      end
      pbh_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = pbh_pkg::ST_DONE;
        end
      end
      pbh_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = pbh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pbh_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/pbh_dp.sv -----
module pbh_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pbh_pkg::pbh_cmd_t                  cmd,
  output pbh_pkg::pbh_stat_t                 stat,
  input  pbh_pkg::pbh_in_t                   in_item,
  input  logic                               cfg_we,
  input  logic [pbh_pkg::SCALE_BITS-1:0]     cfg_data,
  input  logic                               out_stall,
  output logic                               out_valid,
  output pbh_pkg::pbh_out_t                  out_item
);

  localparam int CB = pbh_pkg::COUNT_BITS;
  localparam int PB = pbh_pkg::PROD_BITS;
  localparam int SCALE_BITS_L = pbh_pkg::SCALE_BITS;

  pbh_pkg::pbh_in_t                   item_r;
  logic [pbh_pkg::SCALE_BITS-1:0]     scale_r;
  logic [CB-1:0]                      mem [pbh_pkg::NUM_BINS];
  logic [pbh_pkg::NUM_BINS-1:0]       valid_r;
  logic [CB-1:0]                      rd_r;
  logic                               vld_r;
  logic [pbh_pkg::BIN_BITS-1:0]       addr_r;
  logic [CB-1:0]                      peak_r;
  logic [CB-1:0]                      count_r;
  logic [CB-1:0]                      rem_r;
  logic [PB-1:0]                      quo_r;
  logic [pbh_pkg::STEP_BITS-1:0]      step_r;
  logic                               out_valid_r;
  pbh_pkg::pbh_out_t                  out_item_r;

  logic [pbh_pkg::SUM_BITS-1:0]       sum;
  logic [pbh_pkg::BRIGHT_BITS-1:0]    bright_prod;
  logic [pbh_pkg::BIN_BITS-1:0]       bright;
  logic [pbh_pkg::BIN_BITS-1:0]       addr;
  logic [CB-1:0]                      cnt_cur;
  logic [CB-1:0]                      cnt_new;
  logic [CB:0]                        rem_sh;
  logic [CB:0]                        rem_diff;
  logic                               rem_ge;
  logic [SCALE_BITS_L-1:0]            bar;

  // brightness is floor(sum / 3), exact for sums up to 765
  assign sum = pbh_pkg::SUM_BITS'(item_r.red) + pbh_pkg::SUM_BITS'(item_r.green)
             + pbh_pkg::SUM_BITS'(item_r.blue);
  assign bright_prod = pbh_pkg::BRIGHT_BITS'(sum) * pbh_pkg::BRIGHT_BITS'(pbh_pkg::RECIP);
  assign bright = bright_prod[pbh_pkg::RECIP_SHIFT +: pbh_pkg::BIN_BITS];
  assign addr = (item_r.opcode == pbh_pkg::OP_PIXEL) ? bright : item_r.bin_index;

  // a bin never written since reset or clear reads as zero
  assign cnt_cur = vld_r ? rd_r : '0;
  assign cnt_new = (cnt_cur == pbh_pkg::COUNT_LIMIT) ? cnt_cur : cnt_cur + CB'(1);

  // restoring division step
  assign rem_sh   = {rem_r, quo_r[PB-1]};
  assign rem_ge   = (rem_sh >= {1'b0, peak_r});
  assign rem_diff = rem_sh - {1'b0, peak_r};

  always_comb begin
    if (peak_r == '0) begin
      bar = '0;
    end else if (quo_r > PB'(scale_r)) begin
      bar = scale_r;
    end else begin
      bar = quo_r[SCALE_BITS_L-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= pbh_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_write) begin
      mem[addr_r] <= cnt_new;
    end
    if (cmd.fetch) begin
      rd_r   <= mem[addr];
      vld_r  <= valid_r[addr];
      addr_r <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      peak_r  <= '0;
    end else if (cmd.clear) begin
      valid_r <= '0;
      peak_r  <= '0;
    end else if (cmd.pix_write) begin
      valid_r[addr_r] <= 1'b1;
      if (cnt_new > peak_r) begin
        peak_r <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mult_load) begin
      count_r <= cnt_cur;
      quo_r   <= PB'(cnt_cur) * PB'(scale_r);
      rem_r   <= '0;
      step_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= rem_ge ? rem_diff[CB-1:0] : rem_sh[CB-1:0];
      quo_r  <= {quo_r[PB-2:0], rem_ge};
      step_r <= step_r + pbh_pkg::STEP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_r.bin_count  <= pbh_pkg::to_out_count(count_r);
      out_item_r.max_count  <= pbh_pkg::to_out_count(peak_r);
      out_item_r.bar_height <= bar;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_item      = out_item_r;
  assign stat.opcode   = item_r.opcode;
  assign stat.div_done = (step_r == pbh_pkg::STEP_BITS'(PB - 1));
  assign stat.out_free = !out_valid_r || !out_stall;

endmodule

// ----- hw/rtl/pixel_brightness_histogram.sv -----
// pixel item: fetch, then update, before the next item is accepted
// clear item: fetch with clear, then idle; unused opcode: fetch, then idle, no effect
// read item: fetch, multiply load, then the 38-step serial divider for count * full_scale / max,
//   then the result register once the output is free; next item taken once the result is registered
// reset (synchronous, active low) empties all bins through per-bin valid flags,
//   zeroes the maximum and sets full scale to 256; no clearing pass
module pixel_brightness_histogram (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pbh_pkg::pbh_in_t                in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pbh_pkg::pbh_out_t               out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pbh_pkg::SCALE_BITS-1:0]  cfg_data
);

  pbh_pkg::pbh_cmd_t  cmd;
  pbh_pkg::pbh_stat_t stat;
  logic               cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  pbh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pbh_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is still in work");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result appeared without a read completing");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

  a_count_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.bin_count <= out_item.max_count))
    else $error("bin count above running maximum");

endmodule
